// ===== rtl/core/efhx_pkg.sv =====
// Shared constants and types for the escaped frame header extractor.
package efhx_pkg;

    localparam logic [7:0] ESC_CODE = 8'h1B;
    localparam logic [7:0] OPEN_A   = 8'h02;
    localparam logic [7:0] OPEN_B   = 8'h01;
    localparam logic [7:0] CLOSE_A  = 8'h03;
    localparam logic [7:0] CLOSE_B  = 8'h0A;
    localparam logic [7:0] LIT_DLE  = 8'h10;

    localparam int STORE_BASE = 3;
    localparam int PAY_FIRST  = 9;
    localparam int PAY_LAST   = 16;

    typedef struct packed {
        logic add_byte;
        logic close_good;
        logic close_bad;
    } efhx_ctl_t;

endpackage

// ===== rtl/core/efhx_cell.sv =====
// One byte cell of the frame storage chain.
module efhx_cell
    import efhx_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] d_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? d_in : byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign d_out = byte_reg;

endmodule

// ===== rtl/core/efhx_decode.sv =====
// Escape, framing and byte count tracking for the incoming byte stream.
module efhx_decode
    import efhx_pkg::*;
#(
    parameter int FRAME_LEN = 17
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  logic [7:0] rx_byte,
    output efhx_ctl_t ctl
);

    localparam int CNT_W = $clog2(FRAME_LEN + 2);
    localparam logic [CNT_W-1:0] LEN_C = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] SAT_C = CNT_W'(FRAME_LEN + 1);

    logic             esc_reg, esc_next;
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        esc_next       = esc_reg;
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        ctl            = '0;
        if (accept) begin
            if (!esc_reg) begin
                if (rx_byte == ESC_CODE) begin
                    esc_next = 1'b1;
                end else if (in_frame_reg) begin
                    ctl.add_byte = 1'b1;
                end
            end else begin
                esc_next = 1'b0;
                case (rx_byte) inside
                    OPEN_A, OPEN_B: begin
                        in_frame_next = !in_frame_reg;
                        count_next    = '0;
                    end
                    CLOSE_A, CLOSE_B: begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        if (in_frame_reg) begin
                            ctl.close_good = (count_reg == LEN_C);
                            ctl.close_bad  = (count_reg != LEN_C);
                        end
                    end
                    LIT_DLE, ESC_CODE: begin
                        if (in_frame_reg) begin
                            ctl.add_byte = 1'b1;
                        end else begin
                            count_next = '0;
                        end
                    end
                    default: begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                    end
                endcase
            end
            if (ctl.add_byte && count_reg < SAT_C) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg      <= 1'b0;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            esc_reg      <= esc_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== rtl/core/escaped_frame_header_extractor.sv =====
// Top level of the escaped frame header extractor.
// The block takes one byte of the escaped stream per request and accepts a
// byte in every cycle in which the result register is empty or being taken.
// A closing escape sequence loads the result register at that same edge, so
// a result appears in the cycle after its closing byte is accepted. Frame bytes
// move through a chain of byte cells, one cell per stored byte, and the
// header fields are read at fixed cells when the frame closes. The only
// stall comes from the result side: s_ready follows m_ready while a result
// is held.
module escaped_frame_header_extractor
    import efhx_pkg::*;
#(
    parameter int FRAME_LEN = 17
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [7:0]  m_source_addr,
    output logic [16:0] m_pgn,
    output logic [15:0] m_time_ticks,
    output logic [15:0] m_wrap_count,
    output logic [63:0] m_payload
);

    localparam int DEPTH = FRAME_LEN - STORE_BASE;

    logic      accept;
    efhx_ctl_t ctl;
    logic [7:0] chain [DEPTH];
    logic [7:0] fb [PAY_LAST:STORE_BASE];

    logic        m_valid_reg, m_valid_next;
    logic        status_reg, status_next;
    logic [7:0]  source_reg, source_next;
    logic [16:0] pgn_reg, pgn_next;
    logic [15:0] time_reg, time_next;
    logic [15:0] wrapout_reg, wrapout_next;
    logic [63:0] payload_reg, payload_next;
    logic [15:0] last_time_reg, last_time_next;
    logic [15:0] wrap_reg, wrap_next;
    logic [15:0] frame_time;
    logic [63:0] frame_payload;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    efhx_decode #(.FRAME_LEN(FRAME_LEN)) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .ctl     (ctl)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            efhx_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctl.add_byte),
                .d_in     (s_rx_byte),
                .d_out    (chain[k])
            );
        end else begin : g_body
            efhx_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctl.add_byte),
                .d_in     (chain[k-1]),
                .d_out    (chain[k])
            );
        end
    end

    // The newest byte sits in cell zero, so frame byte p is in cell FRAME_LEN-1-p.
    for (genvar p = STORE_BASE; p <= PAY_LAST; p++) begin : g_pos
        if (p < FRAME_LEN) begin : g_held
            assign fb[p] = chain[FRAME_LEN - 1 - p];
        end else begin : g_none
            assign fb[p] = 8'h00;
        end
    end

    for (genvar j = 0; j < PAY_LAST - PAY_FIRST + 1; j++) begin : g_pay
        assign frame_payload[8*j +: 8] = fb[PAY_FIRST + j];
    end

    assign frame_time = {fb[4], fb[3]};

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        source_next    = source_reg;
        pgn_next       = pgn_reg;
        time_next      = time_reg;
        wrapout_next   = wrapout_reg;
        payload_next   = payload_reg;
        last_time_next = last_time_reg;
        wrap_next      = wrap_reg;
        if (ctl.close_good) begin
            if (frame_time < last_time_reg) begin
                wrap_next = wrap_reg + 16'd1;
            end
            last_time_next = frame_time;
            m_valid_next   = 1'b1;
            status_next    = 1'b0;
            source_next    = fb[5];
            pgn_next       = {fb[8][0], fb[7], fb[6]};
            time_next      = frame_time;
            wrapout_next   = wrap_next;
            payload_next   = frame_payload;
        end else if (ctl.close_bad) begin
            m_valid_next = 1'b1;
            status_next  = 1'b1;
            source_next  = '0;
            pgn_next     = '0;
            time_next    = '0;
            wrapout_next = '0;
            payload_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            last_time_reg <= '0;
            wrap_reg      <= '0;
        end else begin
            m_valid_reg   <= m_valid_next;
            last_time_reg <= last_time_next;
            wrap_reg      <= wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        source_reg  <= source_next;
        pgn_reg     <= pgn_next;
        time_reg    <= time_next;
        wrapout_reg <= wrapout_next;
        payload_reg <= payload_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_source_addr = source_reg;
    assign m_pgn         = pgn_reg;
    assign m_time_ticks  = time_reg;
    assign m_wrap_count  = wrapout_reg;
    assign m_payload     = payload_reg;

`ifndef NO_ASSERTIONS
    a_one_close: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.close_good && ctl.close_bad))
        else $error("Good and bad close in the same cycle.");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg) |-> (payload_reg == '0 && pgn_reg == '0
        && source_reg == '0 && time_reg == '0 && wrapout_reg == '0))
        else $error("Wrong-length result carries nonzero fields.");

    a_wrap_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(wrap_reg)) |->
        (wrap_reg == $past(wrap_reg) + 16'd1))
        else $error("Rollover count moved by other than one.");

    a_wrap_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !status_reg) |-> (wrapout_reg == wrap_reg))
        else $error("Reported rollover count differs from the running count.");
`endif

endmodule

// ===== tb/escaped_frame_header_extractor_tb.sv =====
// Self-checking testbench for the escaped frame header extractor.
`timescale 1ns / 100ps

module escaped_frame_header_extractor_tb;
    import efhx_pkg::*;

    localparam int FRAME_LEN      = 17;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int MIN_FRAMES     = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 26;

    localparam logic ST_GOOD    = 1'b0;
    localparam logic ST_BAD_LEN = 1'b1;

    typedef struct packed {
        logic        status;
        logic [7:0]  source_addr;
        logic [16:0] pgn;
        logic [15:0] time_ticks;
        logic [15:0] wrap_count;
        logic [63:0] payload;
    } frame_result_t;

    localparam frame_result_t BAD_LEN_RESULT = '{ST_BAD_LEN, 8'h00, 17'h0, 16'h0, 16'h0, 64'h0};

    typedef struct packed {
        logic [7:0] rx;
        logic       bad_len;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ESC_CODE, 1'b0}, '{CLOSE_A, 1'b0},
        '{ESC_CODE, 1'b0}, '{LIT_DLE, 1'b0},
        '{ESC_CODE, 1'b0}, '{ESC_CODE, 1'b0},
        '{8'h55, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0},
        '{ESC_CODE, 1'b0}, '{OPEN_B, 1'b0}, '{ESC_CODE, 1'b0}, '{CLOSE_B, 1'b1},
        '{ESC_CODE, 1'b0}, '{OPEN_A, 1'b0}, '{ESC_CODE, 1'b0}, '{OPEN_B, 1'b0},
        '{ESC_CODE, 1'b0}, '{CLOSE_A, 1'b0},
        '{ESC_CODE, 1'b0}, '{OPEN_A, 1'b0}, '{8'hFF, 1'b0},
        '{ESC_CODE, 1'b0}, '{8'h7F, 1'b0},
        '{ESC_CODE, 1'b0}, '{CLOSE_B, 1'b0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic [7:0]  m_source_addr;
    logic [16:0] m_pgn;
    logic [15:0] m_time_ticks;
    logic [15:0] m_wrap_count;
    logic [63:0] m_payload;

    escaped_frame_header_extractor #(
        .FRAME_LEN(FRAME_LEN)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_source_addr (m_source_addr),
        .m_pgn         (m_pgn),
        .m_time_ticks  (m_time_ticks),
        .m_wrap_count  (m_wrap_count),
        .m_payload     (m_payload)
    );

    // Deframer state mirrored by the testbench.
    logic        esc_seen;
    logic        frame_open;
    logic [4:0]  frame_cnt;
    logic [7:0]  held_bytes [STORE_BASE:FRAME_LEN-1];
    logic [15:0] prev_ticks;
    logic [15:0] wrap_tally;

    frame_result_t expected_frames [$];
    int          frames_closed;
    int          bytes_counted;
    int          mismatches;
    int          quiet_cycles;
    bit          sender_burst;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] held_at(input int pos);
        if (pos >= STORE_BASE && pos < FRAME_LEN) begin
            return held_bytes[pos];
        end
        return 8'h00;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (frame_cnt >= STORE_BASE && frame_cnt < FRAME_LEN) begin
            held_bytes[frame_cnt] = b;
        end
        if (frame_cnt < FRAME_LEN + 1) begin
            frame_cnt = frame_cnt + 5'd1;
        end
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t res);
        logic [15:0] ticks;
        logic [7:0]  pgn_hi;
        res = '0;
        if (!esc_seen) begin
            if (b == ESC_CODE) begin
                esc_seen = 1'b1;
            end else if (frame_open) begin
                store_byte(b);
            end
            return 1'b0;
        end
        esc_seen = 1'b0;
        if ((b == OPEN_A || b == OPEN_B) && !frame_open) begin
            frame_open = 1'b1;
            frame_cnt  = '0;
        end else if ((b == CLOSE_A || b == CLOSE_B) && frame_open) begin
            frame_open = 1'b0;
            if (frame_cnt != FRAME_LEN) begin
                res = BAD_LEN_RESULT;
            end else begin
                ticks = {held_at(4), held_at(3)};
                if (ticks < prev_ticks) begin
                    wrap_tally = wrap_tally + 16'd1;
                end
                prev_ticks = ticks;
                pgn_hi = held_at(8);
                res.status      = ST_GOOD;
                res.source_addr = held_at(5);
                res.pgn         = {pgn_hi[0], held_at(7), held_at(6)};
                res.time_ticks  = ticks;
                res.wrap_count  = wrap_tally;
                for (int i = PAY_FIRST; i <= PAY_LAST; i++) begin
                    res.payload[8*(i-PAY_FIRST) +: 8] = held_at(i);
                end
            end
            frame_cnt = '0;
            return 1'b1;
        end else if ((b == LIT_DLE || b == ESC_CODE) && frame_open) begin
            store_byte(b);
        end else begin
            frame_open = 1'b0;
            frame_cnt  = '0;
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed_bad = 1'b0);
        int            gap;
        frame_result_t res;
        bit            has_res;
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_counted++;
        has_res = deframe_byte(b, res);
        if (typed_bad) begin
            has_res = 1'b1;
            res     = BAD_LEN_RESULT;
        end
        if (has_res) begin
            expected_frames = {expected_frames, res};
            frames_closed++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic send_frame(input int body_len, input bit broken);
        int         break_at;
        int         pick;
        logic [7:0] b;
        break_at = broken ? $urandom_range(0, body_len) : -1;
        send_byte(ESC_CODE);
        send_byte($urandom_range(0, 1) ? OPEN_A : OPEN_B);
        for (int i = 0; i < body_len; i++) begin
            if (i == break_at) begin
                send_byte(ESC_CODE);
                send_byte(8'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = ESC_CODE;
                3: b = LIT_DLE;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if (b == ESC_CODE) begin
                send_byte(ESC_CODE);
                send_byte(ESC_CODE);
            end else if (b == LIT_DLE && $urandom_range(0, 1)) begin
                send_byte(ESC_CODE);
                send_byte(LIT_DLE);
            end else begin
                send_byte(b);
            end
        end
        send_byte(ESC_CODE);
        send_byte($urandom_range(0, 1) ? CLOSE_A : CLOSE_B);
    endtask

    initial begin : stimulus
        int pick;
        int body_len;
        int frame_idx;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = 8'h00;
        esc_seen     = 1'b0;
        frame_open   = 1'b0;
        frame_cnt    = '0;
        prev_ticks   = '0;
        wrap_tally   = '0;
        sender_burst = 1'b0;
        frames_closed = 0;
        bytes_counted = 0;
        frame_idx     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(DIR_TABLE[r].rx, DIR_TABLE[r].bad_len);
        end
        wait_drained();

        while (bytes_counted < RANDOM_ITEMS || frames_closed < MIN_FRAMES) begin
            if ($urandom_range(0, 3) == 0) begin
                sender_burst = !sender_burst;
            end
            pick = $urandom_range(0, 19);
            if (pick < 17) begin
                case ($urandom_range(0, 19))
                    14: body_len = FRAME_LEN - 1;
                    15: body_len = FRAME_LEN + 1;
                    16: body_len = 0;
                    17: body_len = $urandom_range(1, FRAME_LEN - 2);
                    18: body_len = $urandom_range(FRAME_LEN + 2, 30);
                    default: body_len = FRAME_LEN;
                endcase
                send_frame(body_len, 1'b0);
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte($urandom_range(0, 3) == 0 ? ESC_CODE
                                                        : 8'($urandom_range(0, 255)));
                end
            end else begin
                send_frame(FRAME_LEN, 1'b1);
            end
            frame_idx++;
            if (frame_idx % 12 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int hold;
        int taken;
        bit sink_burst;
        m_ready    = 1'b0;
        taken      = 0;
        sink_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                sink_burst = !sink_burst;
            end
            if (taken == 8 || taken == 30) begin
                hold = LONG_HOLD;
            end else if (sink_burst) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 8);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
            taken++;
        end
    end

    initial begin
        mismatches   = 0;
        quiet_cycles = 0;
    end

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        frame_result_t seen;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (m_valid && m_ready) begin
                seen = '{m_status, m_source_addr, m_pgn, m_time_ticks, m_wrap_count,
                         m_payload};
                if (expected_frames.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("unexpected result: status=%0d src=%02h pgn=%05h",
                                 seen.status, seen.source_addr, seen.pgn);
                    end
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    if (seen.status != want.status || seen.source_addr != want.source_addr
                        || seen.pgn != want.pgn || seen.time_ticks != want.time_ticks
                        || seen.wrap_count != want.wrap_count
                        || seen.payload != want.payload) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("exp: st=%0d src=%02h pgn=%05h t=%04h w=%04h p=%016h",
                                     want.status, want.source_addr, want.pgn,
                                     want.time_ticks, want.wrap_count, want.payload);
                            $display("act: st=%0d src=%02h pgn=%05h t=%04h w=%04h p=%016h",
                                     seen.status, seen.source_addr, seen.pgn,
                                     seen.time_ticks, seen.wrap_count, seen.payload);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/efhx_pkg.sv
rtl/core/efhx_cell.sv
rtl/core/efhx_decode.sv
rtl/core/escaped_frame_header_extractor.sv
tb/escaped_frame_header_extractor_tb.sv
